// ----- hw/rtl/cau_pkg.sv -----
// Shared types, widths and helper functions for the complex arithmetic unit.
// No dependencies; every other file of the unit imports this package.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int MW = PW;
  localparam int QW = DW + 2;
  localparam int LOW_W = QW - FB;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS = QW / BITS_PER_STEP;
  localparam int SAT_W = QW + DW + 7;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef logic signed [SAT_W-1:0] wide_t;

  localparam wide_t POS_MAX = wide_t'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam wide_t NEG_MIN = wide_t'(-(64'sd1 <<< (DW - 1)));

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] dvd;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          sat;
  } res_t;

  typedef struct packed {
    logic          is_div;
    logic          div_zero;
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic [1:0]    st;
  } ctl_t;

  function automatic res_t sat_fn(input wide_t v);
    res_t r;
    if (v > POS_MAX) begin
      r.val = POS_MAX[DW-1:0];
      r.sat = 1'b1;
    end else if (v < NEG_MIN) begin
      r.val = NEG_MIN[DW-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic res_t div_res(input div_lane_t l);
    res_t  r;
    wide_t v;
    v = wide_t'({1'b0, l.q});
    if (l.neg) begin
      v = -v;
    end
    if (l.ovf) begin
      r.val = l.neg ? NEG_MIN[DW-1:0] : POS_MAX[DW-1:0];
      r.sat = 1'b1;
    end else begin
      r = sat_fn(v);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cau_div_step.sv -----
// One stage of the restoring divider: two quotient bits per pass.
// Depends on cau_pkg for the lane record and widths.
`timescale 1ns / 1ps

module cau_div_step (
  input  cau_pkg::div_lane_t    lane_in,
  input  logic [cau_pkg::MW-1:0] den,
  output cau_pkg::div_lane_t    lane_out
);
  import cau_pkg::*;

  logic [MW:0] trial;
  div_lane_t   l;

  always_comb begin
    l = lane_in;
    trial = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {l.rem, l.dvd[QW-1]};
      l.dvd = {l.dvd[QW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        l.q = {l.q[QW-2:0], 1'b1};
      end else begin
        l.q = {l.q[QW-2:0], 1'b0};
      end
      l.rem = trial[MW-1:0];
    end
    lane_out = l;
  end

endmodule

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit: operand, product, sum and setup stages,
// a pipelined divider and the output register. Depends on cau_pkg and cau_div_step.
`timescale 1ns / 1ps

// The unit takes one word per cycle while the output is not stalled and returns one
// result word for each, in order. The divider resolves two quotient bits per stage over
// nine stages; add, subtract and multiply travel the same pipeline. A stall at the output
// holds the whole pipeline.
module complex_arithmetic_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic signed [15:0]   a_real,
  input  logic signed [15:0]   a_imag,
  input  logic signed [15:0]   b_real,
  input  logic signed [15:0]   b_imag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   result_real,
  output logic signed [15:0]   result_imag,
  output logic [1:0]           status
);
  import cau_pkg::*;

  logic ce;

  logic                 v0;
  kind_t                kind0;
  logic signed [DW-1:0] ar0, ai0, br0, bi0;

  logic                 v1;
  kind_t                kind1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, d_rr, d_ii;
  logic signed [DW:0]   as_re, as_im;

  logic                 v2;
  kind_t                kind2;
  logic signed [SW-1:0] sum_re, sum_im;
  logic [MW-1:0]        den2;

  logic      vd   [0:DIV_STEPS];
  ctl_t      ctl  [0:DIV_STEPS];
  div_lane_t lre  [0:DIV_STEPS];
  div_lane_t lim  [0:DIV_STEPS];
  logic [MW-1:0] den [0:DIV_STEPS];
  div_lane_t nre  [0:DIV_STEPS-1];
  div_lane_t nim  [0:DIV_STEPS-1];

  logic signed [SW-1:0] sr_next, si_next;
  ctl_t      ctl_next;
  div_lane_t lre_next, lim_next;
  res_t      rr, ri, dr, di;

  assign ce = !out_valid || out_ready;
  assign in_ready = ce;

  function automatic div_lane_t lane_init(input logic signed [SW-1:0] s,
                                          input logic [MW-1:0] d);
    div_lane_t     l;
    logic [SW-1:0] a;
    logic [MW-1:0] m;
    a = s[SW-1] ? SW'(-s) : SW'(s);
    m = a[MW-1:0];
    l.rem = MW'(m[MW-1:LOW_W]);
    l.dvd = {m[LOW_W-1:0], {FB{1'b0}}};
    l.q = '0;
    l.neg = s[SW-1];
    l.ovf = (MW'(m[MW-1:LOW_W]) >= d);
    return l;
  endfunction

  always_comb begin
    unique case (kind1)
      KIND_ADD, KIND_SUB: begin
        sr_next = SW'(as_re);
        si_next = SW'(as_im);
      end
      KIND_MUL: begin
        sr_next = SW'(p_rr) - SW'(p_ii);
        si_next = SW'(p_ri) + SW'(p_ir);
      end
      default: begin
        sr_next = SW'(p_rr) + SW'(p_ii);
        si_next = SW'(p_ir) - SW'(p_ri);
      end
    endcase
  end

  always_comb begin
    if (kind2 == KIND_MUL) begin
      rr = sat_fn(wide_t'(sum_re >>> FB));
      ri = sat_fn(wide_t'(sum_im >>> FB));
    end else begin
      rr = sat_fn(wide_t'(sum_re));
      ri = sat_fn(wide_t'(sum_im));
    end
    ctl_next.is_div = (kind2 == KIND_DIV);
    ctl_next.div_zero = (den2 == '0);
    ctl_next.re = rr.val;
    ctl_next.im = ri.val;
    ctl_next.st = (rr.sat || ri.sat) ? ST_SAT : ST_OK;
    lre_next = lane_init(sum_re, den2);
    lim_next = lane_init(sum_im, den2);
  end

  generate
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      cau_div_step u_re (.lane_in(lre[k]), .den(den[k]), .lane_out(nre[k]));
      cau_div_step u_im (.lane_in(lim[k]), .den(den[k]), .lane_out(nim[k]));
    end
  endgenerate

  assign dr = div_res(lre[DIV_STEPS]);
  assign di = div_res(lim[DIV_STEPS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        vd[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (ce) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      vd[0] <= v2;
      for (int k = 0; k < DIV_STEPS; k++) begin
        vd[k+1] <= vd[k];
      end
      out_valid <= vd[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      kind0 <= kind_t'(kind);
      ar0 <= a_real;
      ai0 <= a_imag;
      br0 <= b_real;
      bi0 <= b_imag;

      kind1 <= kind0;
      p_rr <= ar0 * br0;
      p_ii <= ai0 * bi0;
      p_ri <= ar0 * bi0;
      p_ir <= ai0 * br0;
      d_rr <= br0 * br0;
      d_ii <= bi0 * bi0;
      if (kind0 == KIND_SUB) begin
        as_re <= (DW+1)'(ar0) - (DW+1)'(br0);
        as_im <= (DW+1)'(ai0) - (DW+1)'(bi0);
      end else begin
        as_re <= (DW+1)'(ar0) + (DW+1)'(br0);
        as_im <= (DW+1)'(ai0) + (DW+1)'(bi0);
      end

      kind2 <= kind1;
      sum_re <= sr_next;
      sum_im <= si_next;
      den2 <= MW'(d_rr) + MW'(d_ii);

      ctl[0] <= ctl_next;
      lre[0] <= lre_next;
      lim[0] <= lim_next;
      den[0] <= den2;
      for (int k = 0; k < DIV_STEPS; k++) begin
        ctl[k+1] <= ctl[k];
        lre[k+1] <= nre[k];
        lim[k+1] <= nim[k];
        den[k+1] <= den[k];
      end

      if (!ctl[DIV_STEPS].is_div) begin
        result_real <= ctl[DIV_STEPS].re;
        result_imag <= ctl[DIV_STEPS].im;
        status <= ctl[DIV_STEPS].st;
      end else if (ctl[DIV_STEPS].div_zero) begin
        result_real <= '0;
        result_imag <= '0;
        status <= ST_DIVZ;
      end else begin
        result_real <= dr.val;
        result_imag <= di.val;
        status <= (dr.sat || di.sat) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

// ----- hw/rtl/cau_checker.sv -----
// Port-level checks for the complex arithmetic unit and the bind that attaches them.
// Depends on cau_pkg and on the complex_arithmetic_unit port list.
`timescale 1ns / 1ps

module cau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_real,
  input logic [15:0] result_imag,
  input logic [1:0]  status
);
  import cau_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output word valid right after reset.");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("Input ready does not follow the output stall.");

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DIVZ) |-> (result_real == '0 && result_imag == '0))
    else $error("Division by zero word carries a nonzero result.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_real)
      && $stable(result_imag) && $stable(status)))
    else $error("Stalled output word changed.");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .result_real(result_real),
  .result_imag(result_imag),
  .status(status)
);
